>>> hw/rtl/gn2_pkg.sv
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared constants, codes and types of the 2-D gradient noise evaluator.
// ----------------------------------------------------------------------------
package gn2_pkg;

	localparam int GRID_XB = 3;
	localparam int GRID_YB = 3;
	localparam int GRID_X  = 1 << GRID_XB;
	localparam int GRID_Y  = 1 << GRID_YB;

	localparam int PIX_W  = 12;
	localparam int SIZE_W = 13;
	localparam int FRAC_W = 12;
	localparam int CELL_W = 3;
	localparam int GRAD_W = 16;
	localparam int ENTRY_W = 2 * GRAD_W;
	localparam int OUT_W  = 16;

	localparam int GRID_MAXB = (GRID_XB > GRID_YB) ? GRID_XB : GRID_YB;
	// quotient width of the grid scaling divide
	localparam int DIV_W = PIX_W + FRAC_W + GRID_MAXB;

	// each RAM bank holds one column parity
	localparam int RAM_AW    = GRID_XB - 1 + GRID_YB;
	localparam int RAM_DEPTH = 1 << RAM_AW;

	localparam logic CMD_EVAL  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [CELL_W-1:0]        cell_x;
		logic [CELL_W-1:0]        cell_y;
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
	} tag_t;

endpackage

>>> hw/rtl/gn2_scale.sv
// ----------------------------------------------------------------------------
// gn2_scale
// Pipelined restoring divider, one quotient bit per stage, for both axes.
// ----------------------------------------------------------------------------
module gn2_scale import gn2_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  tag_t              in_tag,
	input  logic [PIX_W-1:0]  pixel_x,
	input  logic [PIX_W-1:0]  pixel_y,
	input  logic [SIZE_W-1:0] div_x,
	input  logic [SIZE_W-1:0] div_y,
	output logic              out_vld,
	output tag_t              out_tag,
	output logic [DIV_W-1:0]  quo_x,
	output logic [DIV_W-1:0]  quo_y
);

	typedef struct packed {
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  quo;
		logic [SIZE_W-1:0] rem;
	} axis_t;

	function automatic axis_t axis_step(input axis_t a, input logic [SIZE_W-1:0] d);
		axis_t         r;
		logic [SIZE_W:0] t;
		t = {a.rem, a.num[DIV_W-1]};
		r.num = {a.num[DIV_W-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = SIZE_W'(t - {1'b0, d});
			r.quo = {a.quo[DIV_W-2:0], 1'b1};
		end else begin
			r.rem = t[SIZE_W-1:0];
			r.quo = {a.quo[DIV_W-2:0], 1'b0};
		end
		return r;
	endfunction

	axis_t ax_s [DIV_W];
	axis_t ay_s [DIV_W];
	tag_t  tag_s [DIV_W];
	logic  vld_s [DIV_W];
	axis_t ax_d [DIV_W];
	axis_t ay_d [DIV_W];
	axis_t ax_in, ay_in;

	always_comb begin
		ax_in.num = DIV_W'({pixel_x, {(FRAC_W + GRID_XB){1'b0}}});
		ax_in.quo = '0;
		ax_in.rem = '0;
		ay_in.num = DIV_W'({pixel_y, {(FRAC_W + GRID_YB){1'b0}}});
		ay_in.quo = '0;
		ay_in.rem = '0;
		ax_d[0] = axis_step(ax_in, div_x);
		ay_d[0] = axis_step(ay_in, div_y);
		for (int i = 1; i < DIV_W; i++) begin
			ax_d[i] = axis_step(ax_s[i-1], div_x);
			ay_d[i] = axis_step(ay_s[i-1], div_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_W; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < DIV_W; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < DIV_W; i++) tag_s[i] <= tag_s[i-1];
			for (int i = 0; i < DIV_W; i++) begin
				ax_s[i] <= ax_d[i];
				ay_s[i] <= ay_d[i];
			end
		end
	end

	assign out_vld = vld_s[DIV_W-1];
	assign out_tag = tag_s[DIV_W-1];
	assign quo_x   = ax_s[DIV_W-1].quo;
	assign quo_y   = ay_s[DIV_W-1].quo;

endmodule

>>> hw/rtl/gn2_grad_ram.sv
// ----------------------------------------------------------------------------
// gn2_grad_ram
// Gradient bank: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gn2_grad_ram import gn2_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [RAM_AW-1:0]  waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [RAM_AW-1:0]  raddr_a,
	input  logic [RAM_AW-1:0]  raddr_b,
	output logic [ENTRY_W-1:0] rdata_a,
	output logic [ENTRY_W-1:0] rdata_b
);

	logic [ENTRY_W-1:0] mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> hw/rtl/gn2_interp.sv
// ----------------------------------------------------------------------------
// gn2_interp
// Corner dot products, x then y linear blend, rounding and saturation.
// ----------------------------------------------------------------------------
module gn2_interp import gn2_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic [FRAC_W-1:0]  fx,
	input  logic [FRAC_W-1:0]  fy,
	input  logic [ENTRY_W-1:0] g11,
	input  logic [ENTRY_W-1:0] g21,
	input  logic [ENTRY_W-1:0] g12,
	input  logic [ENTRY_W-1:0] g22,
	output logic               out_vld,
	output logic signed [OUT_W-1:0] noise_value
);

	localparam int OFF_W  = FRAC_W + 1;
	localparam int PROD_W = OFF_W + GRAD_W;
	localparam int DOT_W  = PROD_W + 1;
	localparam int WX_W   = FRAC_W + 2;
	localparam int XP_W   = DOT_W + WX_W;
	localparam int ROW_W  = 42;
	localparam int YP_W   = ROW_W + WX_W;
	localparam int ACC_W  = YP_W + 1;
	localparam int SHIFT  = 36;
	localparam int RND_W  = ACC_W - SHIFT;
	localparam logic [FRAC_W:0] ONE = 1 << FRAC_W;

	logic signed [OFF_W-1:0] lx, ly, hx, hy;
	logic signed [OFF_W-1:0] ox [4];
	logic signed [OFF_W-1:0] oy [4];
	logic [ENTRY_W-1:0]      ge [4];

	assign lx = signed'({1'b0, fx});
	assign ly = signed'({1'b0, fy});
	assign hx = (fx == '0) ? '0 : signed'({1'b1, fx});
	assign hy = (fy == '0) ? '0 : signed'({1'b1, fy});

	always_comb begin
		ge[0] = g11; ox[0] = lx; oy[0] = ly;
		ge[1] = g21; ox[1] = hx; oy[1] = ly;
		ge[2] = g12; ox[2] = lx; oy[2] = hy;
		ge[3] = g22; ox[3] = hx; oy[3] = hy;
	end

	logic [5:0]              vld_q;
	logic [FRAC_W-1:0]       fx_s1, fx_s2, fy_s1, fy_s2, fy_s3, fy_s4;
	logic signed [PROD_W-1:0] px_s1 [4];
	logic signed [PROD_W-1:0] py_s1 [4];
	logic signed [DOT_W-1:0]  dot_s2 [4];
	logic signed [XP_W-1:0]   xp_s3 [4];
	logic signed [ROW_W-1:0]  row_lo_s4, row_hi_s4;
	logic signed [YP_W-1:0]   yp_lo_s5, yp_hi_s5;

	logic signed [ACC_W-1:0] acc;
	logic signed [RND_W-1:0] rnd;
	logic signed [XP_W-1:0]  row_lo_w, row_hi_w;
	logic signed [WX_W-1:0]  wx0, wx1, wy0, wy1;

	assign wx0 = signed'(WX_W'(ONE - {1'b0, fx_s2}));
	assign wx1 = signed'(WX_W'(fx_s2));
	assign wy0 = signed'(WX_W'(ONE - {1'b0, fy_s4}));
	assign wy1 = signed'(WX_W'(fy_s4));

	assign row_lo_w = XP_W'(xp_s3[0] + xp_s3[1]);
	assign row_hi_w = XP_W'(xp_s3[2] + xp_s3[3]);

	assign acc = ACC_W'(yp_lo_s5) + ACC_W'(yp_hi_s5) + (ACC_W'(1) <<< (SHIFT - 1));
	assign rnd = RND_W'(acc >>> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// dot products
			for (int k = 0; k < 4; k++) begin
				px_s1[k] <= ox[k] * signed'(ge[k][GRAD_W-1:0]);
				py_s1[k] <= oy[k] * signed'(ge[k][ENTRY_W-1:GRAD_W]);
			end
			fx_s1 <= fx;
			fy_s1 <= fy;
			for (int k = 0; k < 4; k++) dot_s2[k] <= DOT_W'(px_s1[k]) + DOT_W'(py_s1[k]);
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			// x blend
			xp_s3[0] <= wx0 * dot_s2[0];
			xp_s3[1] <= wx1 * dot_s2[1];
			xp_s3[2] <= wx0 * dot_s2[2];
			xp_s3[3] <= wx1 * dot_s2[3];
			fy_s3 <= fy_s2;
			row_lo_s4 <= ROW_W'(row_lo_w);
			row_hi_s4 <= ROW_W'(row_hi_w);
			fy_s4 <= fy_s3;
			// y blend
			yp_lo_s5 <= wy0 * row_lo_s4;
			yp_hi_s5 <= wy1 * row_hi_s4;
			// round, saturate
			if (rnd > RND_W'(32767))
				noise_value <= 16'sh7fff;
			else if (rnd < -RND_W'(32768))
				noise_value <= 16'sh8000;
			else
				noise_value <= OUT_W'(rnd);
		end
	end

	assign out_vld = vld_q[5];

endmodule

>>> hw/rtl/gradient_noise_2d_eval.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_eval
// 2-D gradient noise: table writes and pixel evaluations on one word stream.
// Pipeline: a pixel word passes 24 + GRID bits divide stages, one RAM read
//   stage and six blend stages on its way to the output.
// Throughput: one word per cycle; the whole pipe holds only while a result
//   waits at the output register.
// Reset: clears the valid bits and sets both image sizes to 256; the
//   gradient banks are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
module gradient_noise_2d_eval import gn2_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic [PIX_W-1:0]         pixel_x,
	input  logic [PIX_W-1:0]         pixel_y,
	input  logic [CELL_W-1:0]        cell_x,
	input  logic [CELL_W-1:0]        cell_y,
	input  logic signed [GRAD_W-1:0] grad_x,
	input  logic signed [GRAD_W-1:0] grad_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  noise_value
);

	// Configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [SIZE_W-1:0] div_x, div_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// a size of zero divides as one
	assign div_x = (width_q == '0) ? SIZE_W'(1) : width_q;
	assign div_y = (height_q == '0) ? SIZE_W'(1) : height_q;

	// Global advance: every stage moves unless the output word is stuck
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	tag_t in_tag;
	assign in_tag = '{cmd: command, cell_x: cell_x, cell_y: cell_y,
		grad_x: grad_x, grad_y: grad_y};

	// Grid scaling divider
	logic             sc_vld;
	tag_t             sc_tag;
	logic [DIV_W-1:0] quo_x, quo_y;

	gn2_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.in_tag  (in_tag),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.div_x   (div_x),
		.div_y   (div_y),
		.out_vld (sc_vld),
		.out_tag (sc_tag),
		.quo_x   (quo_x),
		.quo_y   (quo_y)
	);

	// Corner indices. The high corner is always floor+1 with wrap; when the
	// fraction is zero its weight is zero, so its value never matters.
	// Neighbor columns differ in parity, so each column bank sees one.
	logic [GRID_XB-1:0] x1, x2, x_even, x_odd;
	logic [GRID_YB-1:0] y1, y2;
	logic               swap;

	assign x1     = quo_x[FRAC_W +: GRID_XB];
	assign y1     = quo_y[FRAC_W +: GRID_YB];
	assign x2     = x1 + 1'b1;
	assign y2     = y1 + 1'b1;
	assign swap   = x1[0];
	assign x_even = swap ? x2 : x1;
	assign x_odd  = swap ? x1 : x2;

	// Table writes take effect at the read point, in stream order, so a
	// later pixel reads them with no forwarding.
	logic              wr_hit, wr_even, wr_odd;
	logic [RAM_AW-1:0] waddr;

	assign wr_hit  = adv && sc_vld && (sc_tag.cmd == CMD_WRITE)
		&& (int'(sc_tag.cell_x) < GRID_X) && (int'(sc_tag.cell_y) < GRID_Y);
	assign wr_even = wr_hit && !sc_tag.cell_x[0];
	assign wr_odd  = wr_hit && sc_tag.cell_x[0];
	assign waddr   = {sc_tag.cell_y[GRID_YB-1:0], sc_tag.cell_x[GRID_XB-1:1]};

	logic [ENTRY_W-1:0] wdata;
	assign wdata = {sc_tag.grad_y, sc_tag.grad_x};

	logic [ENTRY_W-1:0] ev_a, ev_b, od_a, od_b;

	gn2_grad_ram u_ram_even (
		.clk     (clk),
		.we      (wr_even),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (adv),
		.raddr_a ({y1, x_even[GRID_XB-1:1]}),
		.raddr_b ({y2, x_even[GRID_XB-1:1]}),
		.rdata_a (ev_a),
		.rdata_b (ev_b)
	);

	gn2_grad_ram u_ram_odd (
		.clk     (clk),
		.we      (wr_odd),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (adv),
		.raddr_a ({y1, x_odd[GRID_XB-1:1]}),
		.raddr_b ({y2, x_odd[GRID_XB-1:1]}),
		.rdata_a (od_a),
		.rdata_b (od_b)
	);

	// Read stage: hold fraction and bank swap next to the RAM data
	logic              rd_vld_s;
	logic [FRAC_W-1:0] fx_rd_s, fy_rd_s;
	logic              swap_rd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s <= 1'b0;
		end else if (adv) begin
			rd_vld_s <= sc_vld && (sc_tag.cmd == CMD_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_rd_s   <= quo_x[FRAC_W-1:0];
			fy_rd_s   <= quo_y[FRAC_W-1:0];
			swap_rd_s <= swap;
		end
	end

	// Blend and round
	gn2_interp u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (rd_vld_s),
		.fx          (fx_rd_s),
		.fy          (fy_rd_s),
		.g11         (swap_rd_s ? od_a : ev_a),
		.g21         (swap_rd_s ? ev_a : od_a),
		.g12         (swap_rd_s ? od_b : ev_b),
		.g22         (swap_rd_s ? ev_b : od_b),
		.out_vld     (out_valid),
		.noise_value (noise_value)
	);

	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_even && wr_odd))
		else $error("table write hit both banks");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sc_vld) && $stable(rd_vld_s))
		else $error("pipe moved during stall");

	a_eval_rd: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sc_vld && (sc_tag.cmd == CMD_EVAL) |=> rd_vld_s)
		else $error("pixel word lost at read stage");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sc_vld && (sc_tag.cmd == CMD_WRITE) |=> !rd_vld_s)
		else $error("table write produced a result");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gradient_noise_2d_eval: a scoreboard class predicts
// each noise word from its own copy of the gradient table and image sizes and
// checks the output stream in order, across several size settings and
// sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import gn2_pkg::*;

	localparam int PIPE_LAT    = 34;
	localparam int DRAIN_WAIT  = PIPE_LAT + 16;
	localparam int HOLD_CYCLES = 300;
	localparam int N_PHASES    = 6;
	localparam int RANDOM_ITEMS = 130;

	// ------------------------------------------------------------------
	// Scoreboard: own table, own sizes, queue of pending noise words.
	// ------------------------------------------------------------------
	class noise_scoreboard;
		logic [ENTRY_W-1:0] grad_table [GRID_Y][GRID_X];
		logic [SIZE_W-1:0]  width_reg;
		logic [SIZE_W-1:0]  height_reg;
		logic signed [OUT_W-1:0] pending_noise [$];
		int errors;
		int n_evals;
		int n_writes;
		int n_checked;

		function new();
			width_reg  = 13'd256;
			height_reg = 13'd256;
		endfunction

		function void set_size(logic [0:0] idx, logic [SIZE_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		// Scale one axis to grid units: low/high corner, fraction, high offset.
		function automatic void scale_axis(input longint pix, input longint size,
				input longint grid, output int lo, output int hi,
				output longint frac, output longint hoff);
			longint d, g, ip;
			d = (size == 0) ? 1 : size;
			g = (pix * grid * 4096) / d;
			ip = g >>> FRAC_W;
			frac = g & 4095;
			lo = int'(ip % grid);
			hi = (frac != 0) ? int'((ip + 1) % grid) : lo;
			hoff = (frac != 0) ? frac - 4096 : 0;
		endfunction

		function automatic longint dot(int cx, int cy, longint ox, longint oy);
			logic signed [GRAD_W-1:0] gx, gy;
			gx = grad_table[cy][cx][GRAD_W-1:0];
			gy = grad_table[cy][cx][ENTRY_W-1:GRAD_W];
			return ox * longint'(gx) + oy * longint'(gy);
		endfunction

		function automatic logic signed [OUT_W-1:0] predict_noise(
				logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
			int x1, x2, y1, y2;
			longint fx, fy, hx, hy, s1, s2, s3, s4, row_lo, row_hi, acc, r;
			scale_axis(px, width_reg, GRID_X, x1, x2, fx, hx);
			scale_axis(py, height_reg, GRID_Y, y1, y2, fy, hy);
			s1 = dot(x1, y1, fx, fy);
			s2 = dot(x2, y1, hx, fy);
			s3 = dot(x1, y2, fx, hy);
			s4 = dot(x2, y2, hx, hy);
			row_lo = (4096 - fx) * s1 + fx * s2;
			row_hi = (4096 - fx) * s3 + fx * s4;
			acc = (4096 - fy) * row_lo + fy * row_hi;
			// round Q.50 to Q.14, halves up, then saturate
			r = (acc + (longint'(1) <<< 35)) >>> 36;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[OUT_W-1:0];
		endfunction

		// Note one accepted input word.
		function void note_input(tag_t t, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
			if (t.cmd == CMD_WRITE) begin
				grad_table[t.cell_y][t.cell_x] = {t.grad_y, t.grad_x};
				n_writes++;
			end else begin
				pending_noise.push_back(predict_noise(px, py));
				n_evals++;
			end
		endfunction

		task report(string what);
			$display("MISMATCH @%0t: %s", $time, what);
			errors++;
		endtask

		task check_noise(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (pending_noise.size() == 0) begin
				report($sformatf("unexpected noise word %0d", got));
				return;
			end
			want = pending_noise.pop_front();
			n_checked++;
			if (got !== want)
				report($sformatf("noise_value got %0d want %0d", got, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic command;
	logic [PIX_W-1:0] pixel_x, pixel_y;
	logic [CELL_W-1:0] cell_x, cell_y;
	logic signed [GRAD_W-1:0] grad_x, grad_y;
	logic out_valid, out_ready;
	logic signed [OUT_W-1:0] noise_value;

	noise_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;

	gradient_noise_2d_eval u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.grad_x     (grad_x),
		.grad_y     (grad_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.noise_value(noise_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on run time.
	initial begin
		#2000000;
		$display("Timeout waiting for the noise pipe to drain");
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: check every accepted word, then pick next cycle's ready.
	// A hold request forces ready low for a long stretch so the pipe fills.
	initial begin : receiver
		int hold_cnt;
		hold_cnt = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_noise(noise_value);
			if (hold_req && hold_cnt == 0)
				hold_cnt = HOLD_CYCLES;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0)
					hold_req = 1'b0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one word and hold it until accepted; gaps go in before it.
	task automatic send_word(logic cmd, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
			logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
			logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
		tag_t t;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		pixel_x  <= px;
		pixel_y  <= py;
		cell_x   <= cx;
		cell_y   <= cy;
		grad_x   <= gx;
		grad_y   <= gy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		t = '{cmd: cmd, cell_x: cx, cell_y: cy, grad_x: gx, grad_y: gy};
		sb.note_input(t, px, py);
	endtask

	task automatic send_eval(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
		send_word(CMD_EVAL, px, py, CELL_W'($urandom), CELL_W'($urandom),
			GRAD_W'($urandom), GRAD_W'($urandom));
	endtask

	task automatic send_grad(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
			logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
		send_word(CMD_WRITE, PIX_W'($urandom), PIX_W'($urandom), cx, cy, gx, gy);
	endtask

	function automatic logic signed [GRAD_W-1:0] rand_grad();
		case ($urandom_range(9))
			0: return -16'sd16384;
			1: return 16'sd16384;
			default: return GRAD_W'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// Drop valid, wait for every pending word, then let the pipe empty out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_size(logic [0:0] idx, logic [SIZE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_size(idx, val);
	endtask

	initial begin : stimulus
		logic [SIZE_W-1:0] widths  [N_PHASES];
		logic [SIZE_W-1:0] heights [N_PHASES];
		sb = new();
		widths  = '{13'd256, 13'd1, 13'd4096, 13'd0, 13'd640, 13'd3};
		heights = '{13'd256, 13'd4096, 13'd1, 13'd8191, 13'd480, 13'd7};
		hold_req = 1'b0;
		send_idle_pct = 10;
		recv_idle_pct = 81;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		command   = CMD_EVAL;
		pixel_x   = '0;
		pixel_y   = '0;
		cell_x    = '0;
		cell_y    = '0;
		grad_x    = '0;
		grad_y    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole gradient table before any evaluation can read it.
		for (int y = 0; y < GRID_Y; y++)
			for (int x = 0; x < GRID_X; x++)
				send_grad(CELL_W'(x), CELL_W'(y), rand_grad(), rand_grad());

		// Directed: extreme gradients around cell (0,0) and (7,7), edge pixels.
		send_grad(3'd0, 3'd0, 16'sd16384, 16'sd16384);
		send_grad(3'd1, 3'd0, -16'sd16384, 16'sd16384);
		send_grad(3'd0, 3'd1, 16'sd16384, -16'sd16384);
		send_grad(3'd1, 3'd1, -16'sd16384, -16'sd16384);
		send_grad(3'd7, 3'd7, -16'sd16384, 16'sd16384);
		send_eval(12'd0, 12'd0);
		send_eval(12'd31, 12'd31);
		send_eval(12'd16, 12'd16);
		send_eval(12'd32, 12'd32);
		send_eval(12'd255, 12'd255);
		send_eval(12'd4095, 12'd4095);
		send_eval(12'd4095, 12'd0);
		send_eval(12'd0, 12'd4095);
		send_eval(12'd250, 12'd3);
		send_eval(12'd2048, 12'd1000);
		send_eval(12'hAAA, 12'h555);
		send_eval(12'h555, 12'hAAA);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// stall pattern: sender light/receiver heavy, then reversed, then none
			if (ph < 2) begin
				send_idle_pct = 10;
				recv_idle_pct = 81;
			end else if (ph < 4) begin
				send_idle_pct = 81;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_size(REG_IMAGE_WIDTH, widths[ph]);
			write_size(REG_IMAGE_HEIGHT, heights[ph]);
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				if (ph == 4 && i == 20)
					hold_req = 1'b1;
				if (ph == 5 && i == 60)
					drain();
				if ($urandom_range(99) < 20)
					send_grad(CELL_W'($urandom), CELL_W'($urandom), rand_grad(),
						rand_grad());
				else if ($urandom_range(9) == 0)
					send_eval($urandom_range(1) ? 12'd4095 : 12'd0, PIX_W'($urandom));
				else
					send_eval(PIX_W'($urandom), PIX_W'($urandom));
			end
			drain();
		end

		$display("Covered %0d gradient writes and %0d evaluations over %0d size settings,",
			sb.n_writes, sb.n_evals, N_PHASES + 1);
		$display("with %0d noise words checked under mixed stall patterns.", sb.n_checked);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
